FILE: rtl/core/vpbu_pkg.sv
// ----------------------------------------------------------------------------
// vpbu_pkg
// Shared types, widths and codes of the per-pixel background update block.
// ----------------------------------------------------------------------------
package vpbu_pkg;

    localparam int DEF_PIXEL_COUNT = 65536;
    localparam int DEF_MAX_SAMPLES = 20;

    localparam int PIX_W    = 16;
    localparam int VAL_W    = 8;
    localparam int GATE_W   = 16;
    localparam int SLOT_W   = 5;
    localparam int RUN_W    = 8;
    localparam int RADIUS_W = 9;
    localparam int MINM_W   = 5;
    localparam int NSAMP_W  = 5;
    localparam int THR_W    = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'hFF;

    localparam logic [RADIUS_W-1:0] RST_MATCH_RADIUS     = 9'd20;
    localparam logic [MINM_W-1:0]   RST_MIN_MATCHES      = 5'd2;
    localparam logic [NSAMP_W-1:0]  RST_SAMPLES_IN_USE   = 5'd20;
    localparam logic [THR_W-1:0]    RST_PERSIST_THRESHOLD = 8'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_RADIUS      = 2'd0,
        CFG_MIN_MATCHES       = 2'd1,
        CFG_SAMPLES_IN_USE    = 2'd2,
        CFG_PERSIST_THRESHOLD = 2'd3
    } cfg_idx_e;

    typedef enum logic {
        CMD_CLASSIFY = 1'b0,
        CMD_LOAD     = 1'b1
    } cmd_e;

    typedef struct packed {
        logic [RADIUS_W-1:0] match_radius;
        logic [MINM_W-1:0]   min_matches;
        logic [NSAMP_W-1:0]  samples_in_use;
        logic [THR_W-1:0]    persist_threshold;
    } cfg_t;

endpackage

FILE: rtl/core/vibe_pixel_background_update.sv
// ----------------------------------------------------------------------------
// vibe_pixel_background_update
// Per-pixel background classification and sample model update.
// ----------------------------------------------------------------------------
// Takes one request per clock while s_ready is high. Each pixel keeps MAX_SAMPLES 8-bit samples in
// one wide memory word and an 8-bit foreground run count; a request reads both
// on acceptance, compares in the next stage, decides and writes back in the
// stage after, from which its result is registered onto m_valid. A request for
// the same pixel as one of the two requests just ahead of it is held until that
// one has written back, so s_ready drops in that case, and for longer while
// m_ready is low. After reset the run count memory is zeroed one entry a cycle,
// and s_ready stays low meanwhile; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module vibe_pixel_background_update #(
    parameter int PIXEL_COUNT = vpbu_pkg::DEF_PIXEL_COUNT,
    parameter int MAX_SAMPLES = vpbu_pkg::DEF_MAX_SAMPLES
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [vpbu_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [vpbu_pkg::CFG_DATA_W-1:0] cfg_wr_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_command,
    input  logic [vpbu_pkg::PIX_W-1:0]      s_pixel_index,
    input  logic [vpbu_pkg::VAL_W-1:0]      s_pixel_value,
    input  logic [vpbu_pkg::GATE_W-1:0]     s_gate_draw,
    input  logic [vpbu_pkg::SLOT_W-1:0]     s_slot_draw,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [vpbu_pkg::PIX_W-1:0]      m_pixel_out,
    output logic                            m_is_foreground,
    output logic                            m_model_refreshed
);
    import vpbu_pkg::*;

    localparam int ADDR_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int WORD_W  = MAX_SAMPLES * VAL_W;
    localparam int LANE_CW = $clog2(MAX_SAMPLES + 1);
    localparam int CNT_W   = (LANE_CW > MINM_W) ? LANE_CW : MINM_W;

    cfg_t cfg;

    vpbu_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    logic              clr_busy;
    logic [ADDR_W-1:0] clr_addr;

    vpbu_run_clear #(
        .DEPTH (PIXEL_COUNT),
        .AW    (ADDR_W)
    ) u_clear (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clr_busy (clr_busy),
        .clr_addr (clr_addr)
    );

    // pipeline control
    logic advance;
    logic hazard;
    logic accept;

    logic              s1_valid_reg;
    cmd_e              s1_cmd_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [VAL_W-1:0]  s1_val_reg;
    logic              s1_gate_zero_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              s1_in_range_reg;

    logic                   s2_valid_reg;
    cmd_e                   s2_cmd_reg;
    logic [PIX_W-1:0]       s2_pix_reg;
    logic [VAL_W-1:0]       s2_val_reg;
    logic                   s2_gate_zero_reg;
    logic                   s2_in_range_reg;
    logic [MAX_SAMPLES-1:0] s2_match_reg;
    logic [MAX_SAMPLES-1:0] s2_lane_en_reg;
    logic [MAX_SAMPLES-1:0] s2_slot_mask_reg;
    logic [WORD_W-1:0]      s2_word_reg;
    logic [RUN_W-1:0]       s2_run_reg;

    logic             s3_valid_reg;
    logic [PIX_W-1:0] s3_pix_reg;
    logic             s3_fg_reg;
    logic             s3_refr_reg;

    assign advance = !s3_valid_reg || m_ready;
    // the two requests ahead have not written back yet
    assign hazard  = (s1_valid_reg && (s1_pix_reg == s_pixel_index))
                  || (s2_valid_reg && (s2_pix_reg == s_pixel_index));
    assign s_ready = advance && !hazard && !clr_busy;
    assign accept  = s_valid && s_ready;

    // memories
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] samp_rd_data;
    logic [RUN_W-1:0]  run_rd_data;

    logic              samp_we;
    logic [WORD_W-1:0] samp_wdata;
    logic              run_we_pipe;
    logic [RUN_W-1:0]  run_wdata_pipe;
    logic              run_we;
    logic [ADDR_W-1:0] run_waddr;
    logic [RUN_W-1:0]  run_wdata;
    logic [ADDR_W-1:0] s2_addr;

    assign rd_addr = ADDR_W'(s_pixel_index);
    assign s2_addr = ADDR_W'(s2_pix_reg);

    vpbu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PIXEL_COUNT),
        .AW    (ADDR_W)
    ) u_samp_ram (
        .aclk    (aclk),
        .wr_en   (samp_we),
        .wr_addr (s2_addr),
        .wr_data (samp_wdata),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (samp_rd_data)
    );

    assign run_we    = clr_busy ? 1'b1 : run_we_pipe;
    assign run_waddr = clr_busy ? clr_addr : s2_addr;
    assign run_wdata = clr_busy ? '0 : run_wdata_pipe;

    vpbu_ram #(
        .WIDTH (RUN_W),
        .DEPTH (PIXEL_COUNT),
        .AW    (ADDR_W)
    ) u_run_ram (
        .aclk    (aclk),
        .wr_en   (run_we),
        .wr_addr (run_waddr),
        .wr_data (run_wdata),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (run_rd_data)
    );

    // stage 1: request registered, memory read in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg       <= cmd_e'(s_command);
            s1_pix_reg       <= s_pixel_index;
            s1_val_reg       <= s_pixel_value;
            s1_gate_zero_reg <= (s_gate_draw == '0);
            s1_slot_reg      <= s_slot_draw;
            s1_in_range_reg  <= (32'(s_pixel_index) < 32'(PIXEL_COUNT));
        end
    end

    // stage 2: per-sample compare
    logic [MAX_SAMPLES-1:0] match_vec;
    logic [MAX_SAMPLES-1:0] lane_en;
    logic [MAX_SAMPLES-1:0] slot_mask;

    vpbu_match_lanes #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_lanes (
        .samples     (samp_rd_data),
        .pixel_value (s1_val_reg),
        .slot        (s1_slot_reg),
        .cfg         (cfg),
        .match_vec   (match_vec),
        .lane_en     (lane_en),
        .slot_mask   (slot_mask)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg) begin
            s2_cmd_reg       <= s1_cmd_reg;
            s2_pix_reg       <= s1_pix_reg;
            s2_val_reg       <= s1_val_reg;
            s2_gate_zero_reg <= s1_gate_zero_reg;
            s2_in_range_reg  <= s1_in_range_reg;
            s2_match_reg     <= match_vec;
            s2_lane_en_reg   <= lane_en;
            s2_slot_mask_reg <= slot_mask;
            s2_word_reg      <= samp_rd_data;
            s2_run_reg       <= run_rd_data;
        end
    end

    // stage 3: decide, write back, present the result
    logic [CNT_W-1:0]       match_cnt;
    logic                   is_bg;
    logic [RUN_W-1:0]       run_inc;
    logic                   refresh;
    logic [MAX_SAMPLES-1:0] wr_mask;
    logic                   fg_next;
    logic                   refr_next;
    logic                   run_upd;

    assign match_cnt = CNT_W'($countones(s2_match_reg));
    assign is_bg     = match_cnt >= CNT_W'(cfg.min_matches);
    assign run_inc   = (s2_run_reg == RUN_MAX) ? RUN_MAX : (s2_run_reg + RUN_W'(1));
    assign refresh   = run_inc > cfg.persist_threshold;

    always_comb begin
        wr_mask        = '0;
        fg_next        = 1'b0;
        refr_next      = 1'b0;
        run_upd        = 1'b0;
        run_wdata_pipe = '0;
        case (s2_cmd_reg)
            CMD_LOAD: begin
                wr_mask = s2_slot_mask_reg;
            end
            CMD_CLASSIFY: begin
                run_upd = 1'b1;
                if (is_bg) begin
                    wr_mask = s2_gate_zero_reg ? s2_slot_mask_reg : '0;
                end else begin
                    fg_next        = 1'b1;
                    refr_next      = refresh;
                    run_wdata_pipe = run_inc;
                    wr_mask        = refresh ? s2_lane_en_reg : '0;
                end
            end
            default: begin
            end
        endcase
        if (!s2_in_range_reg) begin
            wr_mask   = '0;
            fg_next   = 1'b0;
            refr_next = 1'b0;
            run_upd   = 1'b0;
        end
    end

    for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_merge
        assign samp_wdata[i*VAL_W +: VAL_W] = wr_mask[i] ? s2_val_reg
                                                         : s2_word_reg[i*VAL_W +: VAL_W];
    end

    assign samp_we     = s2_valid_reg && advance && (wr_mask != '0);
    assign run_we_pipe = s2_valid_reg && advance && run_upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (advance) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s2_valid_reg) begin
            s3_pix_reg  <= s2_pix_reg;
            s3_fg_reg   <= fg_next;
            s3_refr_reg <= refr_next;
        end
    end

    assign m_valid           = s3_valid_reg;
    assign m_pixel_out       = s3_pix_reg;
    assign m_is_foreground   = s3_fg_reg;
    assign m_model_refreshed = s3_refr_reg;

`ifndef SYNTH
    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !accept)
        else $error("request accepted during run memory clear");

    a_no_pixel_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !((s1_valid_reg && s1_pix_reg == s_pixel_index)
                  || (s2_valid_reg && s2_pix_reg == s_pixel_index)))
        else $error("request accepted while same pixel awaits write-back");

    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !clr_busy |=> !clr_busy)
        else $error("run memory clear restarted");

    a_refresh_is_fg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_model_refreshed) |-> m_is_foreground)
        else $error("model refresh reported for a background pixel");

    a_stage_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && s2_valid_reg) |=> s3_valid_reg)
        else $error("request lost between decide stage and output");
`endif

endmodule

FILE: rtl/core/vpbu_ram.sv
// ----------------------------------------------------------------------------
// vpbu_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module vpbu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/vpbu_cfg_regs.sv
// ----------------------------------------------------------------------------
// vpbu_cfg_regs
// Configuration register file written through a plain indexed write port.
// ----------------------------------------------------------------------------
module vpbu_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [vpbu_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [vpbu_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output vpbu_pkg::cfg_t                  cfg
);
    import vpbu_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.match_radius      <= RST_MATCH_RADIUS;
            cfg_reg.min_matches       <= RST_MIN_MATCHES;
            cfg_reg.samples_in_use    <= RST_SAMPLES_IN_USE;
            cfg_reg.persist_threshold <= RST_PERSIST_THRESHOLD;
        end else if (cfg_wr_en) begin
            case (cfg_idx_e'(cfg_addr))
                CFG_MATCH_RADIUS: begin
                    cfg_reg.match_radius <= cfg_wr_data[RADIUS_W-1:0];
                end
                CFG_MIN_MATCHES: begin
                    cfg_reg.min_matches <= cfg_wr_data[MINM_W-1:0];
                end
                CFG_SAMPLES_IN_USE: begin
                    cfg_reg.samples_in_use <= cfg_wr_data[NSAMP_W-1:0];
                end
                CFG_PERSIST_THRESHOLD: begin
                    cfg_reg.persist_threshold <= cfg_wr_data[THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/vpbu_run_clear.sv
// ----------------------------------------------------------------------------
// vpbu_run_clear
// Post-reset sweep that zeroes the foreground run memory, one entry a cycle.
// ----------------------------------------------------------------------------
module vpbu_run_clear #(
    parameter int DEPTH = vpbu_pkg::DEF_PIXEL_COUNT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    output logic          clr_busy,
    output logic [AW-1:0] clr_addr
);

    logic          clr_busy_reg;
    logic          clr_busy_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign clr_busy = clr_busy_reg;
    assign clr_addr = clr_addr_reg;

endmodule

FILE: rtl/core/vpbu_match_lanes.sv
// ----------------------------------------------------------------------------
// vpbu_match_lanes
// Per-sample compare lanes: radius match, slots in use and slot select.
// ----------------------------------------------------------------------------
module vpbu_match_lanes #(
    parameter int MAX_SAMPLES = vpbu_pkg::DEF_MAX_SAMPLES
) (
    input  logic [MAX_SAMPLES*vpbu_pkg::VAL_W-1:0] samples,
    input  logic [vpbu_pkg::VAL_W-1:0]             pixel_value,
    input  logic [vpbu_pkg::SLOT_W-1:0]            slot,
    input  vpbu_pkg::cfg_t                         cfg,
    output logic [MAX_SAMPLES-1:0]                 match_vec,
    output logic [MAX_SAMPLES-1:0]                 lane_en,
    output logic [MAX_SAMPLES-1:0]                 slot_mask
);
    import vpbu_pkg::*;

    localparam int LANE_CW = $clog2(MAX_SAMPLES + 1);
    localparam int CNT_W   = (LANE_CW > NSAMP_W) ? LANE_CW : NSAMP_W;

    for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_lane
        logic [VAL_W-1:0] smp;
        logic [VAL_W-1:0] diff;

        assign smp  = samples[i*VAL_W +: VAL_W];
        assign diff = (smp > pixel_value) ? (smp - pixel_value) : (pixel_value - smp);

        assign lane_en[i]   = CNT_W'(i) < CNT_W'(cfg.samples_in_use);
        assign match_vec[i] = lane_en[i] && ({1'b0, diff} < cfg.match_radius);
        // slot outside the samples in use selects nothing
        assign slot_mask[i] = lane_en[i] && (CNT_W'(slot) == CNT_W'(i));
    end

endmodule
